// ===== rtl/tabd_pkg.sv =====
// ----------------------------------------------------------------------------
// tabd_pkg: shared types and constants for the tilt auto-balance drive
// Mode and indicator codes, register indexes, input item layout and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tabd_pkg;

	// balance machine modes
	typedef enum logic [1:0] {
		MODE_DISABLED   = 2'd0,
		MODE_ADVANCING  = 2'd1,
		MODE_CORRECTING = 2'd2,
		MODE_BRAKING    = 2'd3
	} mode_t;

	// tilt indicator codes
	typedef enum logic [1:0] {
		IND_OFF     = 2'd0,
		IND_FORWARD = 2'd1,
		IND_BACK    = 2'd2,
		IND_STOP    = 2'd3
	} ind_t;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DECIDE,
		ST_DIV,
		ST_FINISH
	} state_t;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 15;

	localparam logic [CFG_INDEX_W-1:0] REG_ADVANCE_SPEED  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CORRECT_RATIO  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_BAND     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BRAKE_SPEED    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TILT_IND_LIMIT = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_CORRECT_OFFSET = 3'd6;

	// register reset values
	localparam logic [14:0] RST_ADVANCE_SPEED  = 15'd9830;
	localparam logic [8:0]  RST_CORRECT_RATIO  = 9'd230;
	localparam logic [13:0] RST_LEVEL_BAND     = 14'd100;
	localparam logic [7:0]  RST_SETTLE_TICKS   = 8'd5;
	localparam logic [14:0] RST_BRAKE_SPEED    = 15'd328;
	localparam logic [13:0] RST_TILT_IND_LIMIT = 14'd500;
	localparam logic [14:0] RST_CORRECT_OFFSET = 15'd6554;

	// input item, pitch in the lowest bits
	localparam int PITCH_W    = 15;
	localparam int STICK_W    = 16;
	localparam int IN_TDATA_W = 72;

	typedef struct packed {
		logic [4:0]         pad;
		logic               creep_button;
		logic               wait_button;
		logic               brake_button;
		logic               balance_button;
		logic [STICK_W-1:0] stick_twist;
		logic [STICK_W-1:0] stick_x;
		logic [STICK_W-1:0] stick_y;
		logic [PITCH_W-1:0] pitch;
	} in_item_t;

	// divider: |advance_speed * pitch| stays below 2^30
	localparam int NUM_W     = 30;
	localparam int DIV_STEPS = 2;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic decide;
		logic div_start;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
	} dp_status_t;

endpackage

// ===== rtl/tabd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tabd_ctrl: tick sequencer
// Steps one item through evaluate, decide, optional divide and finish, and
// owns the result register's valid flag.
// ----------------------------------------------------------------------------
module tabd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	input  tabd_pkg::dp_status_t   status,
	output tabd_pkg::ctrl_cmd_t    cmd
);
	import tabd_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid)
					state_nxt = ST_EVAL;
			end
			ST_EVAL:   state_nxt = ST_DECIDE;
			ST_DECIDE: state_nxt = status.need_div ? ST_DIV : ST_FINISH;
			ST_DIV: begin
				if (!status.div_busy)
					state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_EVAL:   cmd.eval = 1'b1;
			ST_DECIDE: begin
				cmd.decide    = 1'b1;
				cmd.div_start = status.need_div;
			end
			ST_FINISH: cmd.finish = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/tabd_divider.sv =====
// ----------------------------------------------------------------------------
// tabd_divider: unsigned restoring divider
// Two quotient bits per cycle; busy from the cycle after start until the
// quotient is complete.
// ----------------------------------------------------------------------------
module tabd_divider #(
	parameter int DEN_W = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tabd_pkg::NUM_W-1:0] numer,
	input  logic [DEN_W-1:0]           denom,
	output logic                       busy,
	output logic [tabd_pkg::NUM_W-1:0] quot
);
	import tabd_pkg::*;

	localparam int ITER  = NUM_W / DIV_STEPS;
	localparam int CNT_W = $clog2(ITER);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITER - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_nxt;
	logic [NUM_W-1:0] quo_nxt;
	logic [DEN_W:0]   trial;

	// quo_q starts as the dividend and fills with quotient bits from the bottom
	always_comb begin
		rem_nxt = rem_q;
		quo_nxt = quo_q;
		trial   = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial   = {rem_nxt, quo_nxt[NUM_W-1]};
			quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial      = trial - {1'b0, den_q};
				quo_nxt[0] = 1'b1;
			end
			rem_nxt = trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

// ===== rtl/tabd_datapath.sv =====
// ----------------------------------------------------------------------------
// tabd_datapath: balance arithmetic, state and result register
// Holds the configuration and tick state, evaluates entry, the advance test,
// level counting and braking, and forms the correcting drive from the divider.
// ----------------------------------------------------------------------------
module tabd_datapath #(
	parameter int DRIVE_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16,
	parameter int OUT_W       = 56
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tabd_pkg::ctrl_cmd_t              cmd,
	output tabd_pkg::dp_status_t             status,
	input  logic                             cfg_we,
	input  logic [tabd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tabd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [tabd_pkg::IN_TDATA_W-1:0]  in_tdata,
	output logic [OUT_W-1:0]                 out_tdata
);
	import tabd_pkg::*;

	localparam int PR_W  = ANGLE_WIDTH + 10;
	localparam int CMP_W = ANGLE_WIDTH + 11;

	localparam logic signed [33:0] DRV_MAX = (34'sd1 <<< (DRIVE_WIDTH - 1)) - 34'sd1;
	localparam logic signed [33:0] DRV_MIN = -DRV_MAX - 34'sd1;
	localparam logic signed [33:0] ANG_MAX = (34'sd1 <<< (ANGLE_WIDTH - 1)) - 34'sd1;
	localparam logic signed [33:0] ANG_MIN = -ANG_MAX - 34'sd1;

	function automatic logic [DRIVE_WIDTH-1:0] sat_drive(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = v;
		if (v > DRV_MAX)
			r = DRV_MAX;
		else if (v < DRV_MIN)
			r = DRV_MIN;
		return r[DRIVE_WIDTH-1:0];
	endfunction

	function automatic logic [ANGLE_WIDTH-1:0] sat_angle(input logic signed [33:0] v);
		logic signed [33:0] r;
		r = v;
		if (v > ANG_MAX)
			r = ANG_MAX;
		else if (v < ANG_MIN)
			r = ANG_MIN;
		return r[ANGLE_WIDTH-1:0];
	endfunction

	// configuration
	logic [14:0] adv_speed_q;
	logic [8:0]  ratio_q;
	logic [13:0] band_q;
	logic [7:0]  settle_q;
	logic [14:0] brake_q;
	logic [13:0] limit_q;
	logic [14:0] offset_q;

	// tick state
	mode_t                          mode_q;
	logic signed [ANGLE_WIDTH-1:0]  peak_q;
	logic                           neg_q;
	logic [7:0]                     level_q;
	logic signed [DRIVE_WIDTH-1:0]  prev_y_q;
	logic                           bal_was_q;
	logic                           creep_on_q;
	logic                           creep_was_q;

	// item and stage registers
	in_item_t                       in_q;
	mode_t                          mode_s1;
	logic signed [ANGLE_WIDTH-1:0]  peak_s1;
	logic                           neg_s1;
	logic signed [PR_W-1:0]         prod_ratio_s1;
	logic signed [30:0]             prod_speed_s1;
	mode_t                          mode_s2;
	logic signed [ANGLE_WIDTH-1:0]  peak_s2;
	logic [7:0]                     level_s2;
	logic [DRIVE_WIDTH-1:0]         y_s2;
	logic                           used_div_s2;
	logic                           q_neg_s2;
	logic [OUT_W-1:0]               out_tdata_q;

	// decoded item
	logic signed [PITCH_W-1:0] pitch;
	logic signed [33:0]        pitch34;
	logic                      held;
	logic                      entering;
	logic                      adv_entry;

	assign pitch     = $signed(in_q.pitch);
	assign pitch34   = 34'(pitch);
	assign held      = in_q.balance_button || in_q.brake_button;
	assign entering  = held && !bal_was_q;
	assign adv_entry = entering && !in_q.brake_button;

	// evaluate: mode entry and the two products
	mode_t                         mode_e;
	logic signed [ANGLE_WIDTH-1:0] peak_e;
	logic                          neg_e;
	logic signed [PR_W-1:0]        prod_ratio_e;
	logic signed [30:0]            prod_speed_e;

	always_comb begin
		if (!held)
			mode_e = MODE_DISABLED;
		else if (entering)
			mode_e = in_q.brake_button ? MODE_BRAKING : MODE_ADVANCING;
		else
			mode_e = mode_q;
		peak_e = adv_entry ? '0 : peak_q;
		neg_e  = adv_entry ? !((pitch > 0) || (prev_y_q > 0)) : neg_q;
	end

	assign prod_ratio_e = peak_e * $signed({1'b0, ratio_q});
	assign prod_speed_e = $signed({1'b0, adv_speed_q}) * pitch;

	// decide: advance test, level counting, braking
	logic signed [CMP_W-1:0]       pr_ext;
	logic signed [CMP_W-1:0]       mag;
	logic signed [CMP_W-1:0]       p256;
	logic                          go;
	logic [PITCH_W-1:0]            apitch;
	mode_t                         mode_d;
	logic signed [ANGLE_WIDTH-1:0] peak_d;
	logic [7:0]                    level_d;
	logic [DRIVE_WIDTH-1:0]        y_d;
	logic                          need_div;

	assign pr_ext = CMP_W'(prod_ratio_s1);
	assign mag    = (pr_ext < 0) ? -pr_ext : pr_ext;
	assign p256   = CMP_W'(pitch) <<< 8;
	assign go     = neg_s1 ? (p256 < -mag) : (p256 > mag);
	assign apitch = (pitch < 0) ? PITCH_W'(-pitch) : PITCH_W'(pitch);

	always_comb begin
		mode_d   = mode_s1;
		peak_d   = peak_s1;
		level_d  = level_q;
		y_d      = sat_drive(34'($signed(in_q.stick_y)));
		need_div = 1'b0;

		if (mode_d == MODE_ADVANCING) begin
			if (go) begin
				y_d = neg_s1 ? sat_drive(-$signed(34'(adv_speed_q)))
				             : sat_drive($signed(34'(adv_speed_q)));
				if (!neg_s1 && (pitch34 > 34'(peak_s1)))
					peak_d = sat_angle(pitch34);
				else if (neg_s1 && (pitch34 < 34'(peak_s1)))
					peak_d = sat_angle(pitch34);
			end else begin
				level_d = '0;
				mode_d  = MODE_CORRECTING;
			end
		end

		if (mode_d == MODE_CORRECTING) begin
			if (apitch < PITCH_W'(band_q)) begin
				if (level_d != 8'hFF)
					level_d = level_d + 8'd1;
				if (level_d >= settle_q)
					mode_d = MODE_BRAKING;
			end else begin
				level_d  = '0;
				// zero peak: quotient taken as zero
				need_div = (peak_s1 != 0);
				y_d      = sat_drive(-$signed(34'(offset_q)));
			end
		end

		if (mode_d == MODE_BRAKING)
			y_d = (prev_y_q > 0) ? sat_drive(-$signed(34'(brake_q)))
			                     : sat_drive($signed(34'(brake_q)));
	end

	// divider on magnitudes, sign restored afterwards (truncation toward zero)
	logic [30:0]             ps_abs;
	logic [ANGLE_WIDTH-1:0]  peak_abs;
	logic                    div_busy;
	logic [NUM_W-1:0]        quot;

	assign ps_abs   = prod_speed_s1[30] ? 31'(-prod_speed_s1) : 31'(prod_speed_s1);
	assign peak_abs = peak_s1[ANGLE_WIDTH-1] ? ANGLE_WIDTH'(-peak_s1)
	                                         : ANGLE_WIDTH'(peak_s1);

	tabd_divider #(
		.DEN_W (ANGLE_WIDTH)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (ps_abs[NUM_W-1:0]),
		.denom  (peak_abs),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign status.need_div = need_div;
	assign status.div_busy = div_busy;

	// finish: result word and committed state
	logic signed [33:0]     q34;
	logic [DRIVE_WIDTH-1:0] y_fin;
	logic [DRIVE_WIDTH-1:0] x_fin;
	logic [DRIVE_WIDTH-1:0] tw_fin;
	logic                   creep_on_nxt;
	logic                   low_gear;
	ind_t                   ind;
	logic signed [16:0]     pitch17;
	logic signed [16:0]     lim17;

	assign q34    = q_neg_s2 ? -$signed(34'(quot)) : $signed(34'(quot));
	assign y_fin  = used_div_s2 ? sat_drive(q34 - $signed(34'(offset_q))) : y_s2;
	assign x_fin  = held ? '0 : sat_drive(34'($signed(in_q.stick_x)));
	assign tw_fin = held ? '0 : sat_drive(34'($signed(in_q.stick_twist)));
	assign creep_on_nxt = (in_q.creep_button && !creep_was_q) ? !creep_on_q : creep_on_q;
	assign low_gear = creep_on_nxt || held;
	assign pitch17  = 17'(pitch);
	assign lim17    = $signed(17'(limit_q));

	always_comb begin
		if (mode_s2 == MODE_DISABLED && !in_q.wait_button) begin
			if (pitch17 < -lim17)
				ind = IND_BACK;
			else if (pitch17 > lim17)
				ind = IND_FORWARD;
			else
				ind = IND_OFF;
		end else begin
			ind = IND_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_speed_q <= RST_ADVANCE_SPEED;
			ratio_q     <= RST_CORRECT_RATIO;
			band_q      <= RST_LEVEL_BAND;
			settle_q    <= RST_SETTLE_TICKS;
			brake_q     <= RST_BRAKE_SPEED;
			limit_q     <= RST_TILT_IND_LIMIT;
			offset_q    <= RST_CORRECT_OFFSET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADVANCE_SPEED:  adv_speed_q <= cfg_data[14:0];
				REG_CORRECT_RATIO:  ratio_q     <= cfg_data[8:0];
				REG_LEVEL_BAND:     band_q      <= cfg_data[13:0];
				REG_SETTLE_TICKS:   settle_q    <= cfg_data[7:0];
				REG_BRAKE_SPEED:    brake_q     <= cfg_data[14:0];
				REG_TILT_IND_LIMIT: limit_q     <= cfg_data[13:0];
				REG_CORRECT_OFFSET: offset_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_DISABLED;
			peak_q      <= '0;
			neg_q       <= 1'b0;
			level_q     <= '0;
			prev_y_q    <= '0;
			bal_was_q   <= 1'b0;
			creep_on_q  <= 1'b0;
			creep_was_q <= 1'b0;
		end else if (cmd.finish) begin
			mode_q      <= mode_s2;
			peak_q      <= peak_s2;
			neg_q       <= neg_s1;
			level_q     <= level_s2;
			prev_y_q    <= $signed(y_fin);
			bal_was_q   <= in_q.balance_button;
			creep_on_q  <= creep_on_nxt;
			creep_was_q <= in_q.creep_button;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= in_item_t'(in_tdata);
		if (cmd.eval) begin
			mode_s1       <= mode_e;
			peak_s1       <= peak_e;
			neg_s1        <= neg_e;
			prod_ratio_s1 <= prod_ratio_e;
			prod_speed_s1 <= prod_speed_e;
		end
		if (cmd.decide) begin
			mode_s2     <= mode_d;
			peak_s2     <= peak_d;
			level_s2    <= level_d;
			y_s2        <= y_d;
			used_div_s2 <= need_div;
			q_neg_s2    <= prod_speed_s1[30] ^ peak_s1[ANGLE_WIDTH-1];
		end
		if (cmd.finish)
			out_tdata_q <= OUT_W'({mode_s2, ind, low_gear, tw_fin, x_fin, y_fin});
	end

	assign out_tdata = out_tdata_q;

endmodule

// ===== rtl/tilt_auto_balance_drive_top.sv =====
// Sequence: an accepted item passes through the evaluate, decide and finish states; a correcting
//   tick that needs a division also waits in the divide state while the divider works (two
//   quotient bits a cycle for a 30 bit quotient). Finish waits for a free result register.
// One item in flight; the next is accepted while the previous result waits in its register.
// Reset (arst_n low, asynchronous): disabled mode, cleared tick state, registers at defaults.
// ----------------------------------------------------------------------------
// tilt_auto_balance_drive_top: joystick drive with tilt auto-balance
// Stream in, stream out, with a register write channel for configuration.
// ----------------------------------------------------------------------------
module tilt_auto_balance_drive_top #(
	parameter int DRIVE_WIDTH = 16,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// pitch[14:0], stick_y, stick_x, stick_twist, balance_button, brake_button,
	// wait_button, creep_button, zero pad
	input  logic [tabd_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// drive_y, drive_x, drive_twist, low_gear, indicator[1:0], mode[1:0], zero pad
	output logic [((3*DRIVE_WIDTH+5+7)/8)*8-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tabd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tabd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tabd_pkg::*;

	localparam int OUT_W = ((3 * DRIVE_WIDTH + 5 + 7) / 8) * 8;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	logic       cfg_we;

	// registers take a write on any cycle
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	tabd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tabd_datapath #(
		.DRIVE_WIDTH (DRIVE_WIDTH),
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.OUT_W       (OUT_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_tdata  (s_tdata),
		.out_tdata (m_tdata)
	);

endmodule

// ===== rtl/tabd_checker.sv =====
// ----------------------------------------------------------------------------
// tabd_checker: port-level checks for the tilt auto-balance drive
// Result hold under back-pressure, one item at a time, balance-mode outputs.
// ----------------------------------------------------------------------------
module tabd_checker #(
	parameter int DRIVE_WIDTH = 16
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [((3*DRIVE_WIDTH+5+7)/8)*8-1:0]  m_tdata
);
	import tabd_pkg::*;

	logic [DRIVE_WIDTH-1:0] drive_x;
	logic [DRIVE_WIDTH-1:0] drive_twist;
	logic                   low_gear;
	logic [1:0]             indicator;
	logic [1:0]             mode;

	assign drive_x     = m_tdata[2*DRIVE_WIDTH-1 -: DRIVE_WIDTH];
	assign drive_twist = m_tdata[3*DRIVE_WIDTH-1 -: DRIVE_WIDTH];
	assign low_gear    = m_tdata[3*DRIVE_WIDTH];
	assign indicator   = m_tdata[3*DRIVE_WIDTH+2 -: 2];
	assign mode        = m_tdata[3*DRIVE_WIDTH+4 -: 2];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// an accepted item blocks the input until its result is formed
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while one is in work");

	// any balance mode forces stop indicator, low gear and no strafe or rotation
	a_balance_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (mode != MODE_DISABLED) |->
			(indicator == IND_STOP) && low_gear && (drive_x == '0) && (drive_twist == '0))
		else $error("balance mode result with free drive outputs");

endmodule

bind tilt_auto_balance_drive_top tabd_checker #(
	.DRIVE_WIDTH (DRIVE_WIDTH)
) u_tabd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/tilt_auto_balance_drive_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_auto_balance_drive_top_tb: self-checking bench for the tilt balance drive
// Streams control ticks into the block under random idling and one long
// receiver hold-off. A local model of the balance machine predicts every
// drive command. The register settings move through defaults, both extremes,
// one fixed set and random values between phases.
// ----------------------------------------------------------------------------
module tilt_auto_balance_drive_top_tb;
	import tabd_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_TICKS = 105;

	typedef struct {
		logic [15:0] drive_y;
		logic [15:0] drive_x;
		logic [15:0] drive_twist;
		logic        low_gear;
		ind_t        indicator;
		mode_t       mode;
	} drive_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	in_item_t s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic sink_hold = 1'b0;

	in_item_t tick_queue[$];
	drive_cmd_t pending_cmds[$];
	int n_queued = 0;
	int n_ticks_in = 0;
	int n_cmds_out = 0;
	int n_cfg_writes = 0;
	int n_errors = 0;
	int stall_cycles = 0;
	int n_advancing = 0;
	int n_correcting = 0;
	int n_braking = 0;

	// register copies
	logic [14:0] adv_speed = RST_ADVANCE_SPEED;
	logic [8:0]  corr_ratio = RST_CORRECT_RATIO;
	logic [13:0] lvl_band = RST_LEVEL_BAND;
	logic [7:0]  settle = RST_SETTLE_TICKS;
	logic [14:0] brk_speed = RST_BRAKE_SPEED;
	logic [13:0] ind_limit = RST_TILT_IND_LIMIT;
	logic [14:0] corr_offset = RST_CORRECT_OFFSET;

	// balance machine state
	mode_t  bal_mode = MODE_DISABLED;
	longint peak = 0;
	bit     adv_neg = 1'b0;
	int     lvl_cnt = 0;
	longint prev_y = 0;
	bit     bal_held = 1'b0;
	bit     creep_on = 1'b0;
	bit     creep_prev = 1'b0;

	tilt_auto_balance_drive_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic drive_cmd_t predict_drive_cmd(in_item_t t);
		longint pitch, y, x, tw, mag, q, apitch;
		bit bal, brk, go;
		drive_cmd_t c;
		pitch = $signed(t.pitch);
		y = $signed(t.stick_y);
		x = $signed(t.stick_x);
		tw = $signed(t.stick_twist);
		bal = t.balance_button;
		brk = t.brake_button;
		if (t.creep_button && !creep_prev) creep_on = !creep_on;
		creep_prev = t.creep_button;
		c.low_gear = creep_on;
		if (bal || brk) begin
			c.low_gear = 1'b1;
			if (!bal_held) begin
				if (brk) begin
					bal_mode = MODE_BRAKING;
				end else begin
					peak = 0;
					bal_mode = MODE_ADVANCING;
					adv_neg = !(pitch > 0 || prev_y > 0);
				end
			end
			x = 0;
			tw = 0;
			if (bal_mode == MODE_ADVANCING) begin
				mag = peak * longint'(corr_ratio);
				if (mag < 0) mag = -mag;
				go = adv_neg ? (pitch * 256 < -mag) : (pitch * 256 > mag);
				if (go) begin
					y = adv_neg ? -longint'(adv_speed) : longint'(adv_speed);
					if (adv_neg ? (pitch < peak) : (pitch > peak)) peak = pitch;
				end else begin
					lvl_cnt = 0;
					bal_mode = MODE_CORRECTING;
				end
			end
			if (bal_mode == MODE_CORRECTING) begin
				apitch = pitch < 0 ? -pitch : pitch;
				if (apitch < longint'(lvl_band)) begin
					// level tick: stick passes through unless the settle count moves it to braking
					if (lvl_cnt < 255) lvl_cnt++;
					if (lvl_cnt >= settle) bal_mode = MODE_BRAKING;
				end else begin
					lvl_cnt = 0;
					q = 0;
					if (peak != 0) q = (longint'(adv_speed) * pitch) / peak;
					y = q - longint'(corr_offset);
					if (y > 32767) y = 32767;
					else if (y < -32768) y = -32768;
				end
			end
			if (bal_mode == MODE_BRAKING)
				y = prev_y > 0 ? -longint'(brk_speed) : longint'(brk_speed);
		end else begin
			bal_mode = MODE_DISABLED;
		end
		bal_held = bal;

		if (bal_mode == MODE_DISABLED && !t.wait_button) begin
			if (pitch < -longint'(ind_limit)) c.indicator = IND_BACK;
			else if (pitch > longint'(ind_limit)) c.indicator = IND_FORWARD;
			else c.indicator = IND_OFF;
		end else begin
			c.indicator = IND_STOP;
		end

		case (bal_mode)
			MODE_ADVANCING: n_advancing++;
			MODE_CORRECTING: n_correcting++;
			MODE_BRAKING: n_braking++;
			default: ;
		endcase

		prev_y = y;
		c.drive_y = y[15:0];
		c.drive_x = x[15:0];
		c.drive_twist = tw[15:0];
		c.mode = bal_mode;
		return c;
	endfunction

	function automatic bit calm_window();
		return n_ticks_in >= 200 && n_ticks_in < 350;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns, command %0d: %s", $time, n_cmds_out, msg);
		n_errors++;
	endtask

	task automatic check_field(string name, longint got, longint want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	task automatic check_drive_cmd(logic [55:0] d);
		drive_cmd_t want;
		if (pending_cmds.size() == 0) begin
			report_mismatch($sformatf("unexpected command 0x%0h", d));
		end else begin
			want = pending_cmds.pop_front();
			check_field("drive_y", d[15:0], want.drive_y);
			check_field("drive_x", d[31:16], want.drive_x);
			check_field("drive_twist", d[47:32], want.drive_twist);
			check_field("low_gear", d[48], want.low_gear);
			check_field("indicator", d[50:49], want.indicator);
			check_field("mode", d[52:51], want.mode);
		end
		n_cmds_out++;
	endtask

	// tick driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_cmds.push_back(predict_drive_cmd(s_tdata));
				n_ticks_in++;
			end
			if (!s_tvalid || s_tready) begin
				if (tick_queue.size() != 0 && (calm_window() || $urandom_range(0, 99) >= 11)) begin
					s_tvalid <= 1'b1;
					s_tdata <= tick_queue.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// command monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) check_drive_cmd(m_tdata);
			m_tready <= !sink_hold && (calm_window() || $urandom_range(0, 99) >= 11);
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (n_ticks_in >= 420);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d commands outstanding",
				stall_cycles, pending_cmds.size());
			$display("tilt_auto_balance_drive_top verification failed");
			$finish;
		end
	end

	task automatic queue_tick(int p, int sy, int sx, int st, bit bal, bit brk, bit wt,
			bit cr);
		in_item_t t;
		t = '0;
		t.pitch = p[14:0];
		t.stick_y = sy[15:0];
		t.stick_x = sx[15:0];
		t.stick_twist = st[15:0];
		t.balance_button = bal;
		t.brake_button = brk;
		t.wait_button = wt;
		t.creep_button = cr;
		tick_queue.push_back(t);
		n_queued++;
	endtask

	function automatic int jitter();
		return $urandom_range(0, 60) - 30;
	endfunction

	// one balance episode: ramp up to a peak, fall back, settle, release
	task automatic queue_balance_run();
		int sgn, pk, nr, nd, nl, i;
		sgn = $urandom_range(0, 1) ? 1 : -1;
		pk = $urandom_range(150, 9000);
		nr = $urandom_range(1, 5);
		nd = $urandom_range(1, 6);
		nl = $urandom_range(0, 8);
		for (i = 1; i <= nr; i++)
			queue_tick(sgn * pk * i / nr + jitter(), $urandom, $urandom, $urandom, 1'b1,
				$urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0,
				$urandom_range(0, 9) == 0);
		for (i = 1; i <= nd; i++)
			queue_tick(sgn * pk * (nd - i) / nd + jitter(), $urandom, $urandom, $urandom,
				1'b1, 1'b0, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
		for (i = 0; i < nl; i++)
			queue_tick($urandom_range(0, 400) - 200, $urandom, $urandom, $urandom, 1'b1,
				$urandom_range(0, 29) == 0, $urandom_range(0, 1), $urandom_range(0, 9) == 0);
		for (i = $urandom_range(1, 3); i > 0; i--)
			queue_tick($urandom_range(0, 18000) - 9000, $urandom, $urandom, $urandom, 1'b0,
				1'b0, $urandom_range(0, 1), $urandom_range(0, 1));
	endtask

	task automatic queue_random_ticks(int count);
		int target, r, i;
		target = n_queued + count;
		while (n_queued < target) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				queue_balance_run();
			end else if (r < 85) begin
				for (i = $urandom_range(1, 4); i > 0; i--)
					queue_tick($urandom_range(0, 18000) - 9000, $urandom, $urandom, $urandom,
						$urandom_range(0, 3) == 0, 1'b1, $urandom_range(0, 1),
						$urandom_range(0, 1));
			end else begin
				for (i = $urandom_range(1, 3); i > 0; i--)
					queue_tick($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1),
						$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
			end
		end
	endtask

	task automatic wait_idle();
		while (n_ticks_in != n_queued || pending_cmds.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ADVANCE_SPEED: adv_speed = val;
			REG_CORRECT_RATIO: corr_ratio = val;
			REG_LEVEL_BAND: lvl_band = val;
			REG_SETTLE_TICKS: settle = val;
			REG_BRAKE_SPEED: brk_speed = val;
			REG_TILT_IND_LIMIT: ind_limit = val;
			REG_CORRECT_OFFSET: corr_offset = val;
			default: ;
		endcase
		n_cfg_writes++;
	endtask

	task automatic apply_settings(int adv, int ratio, int band, int ticks, int brk, int lim,
			int off);
		write_reg(REG_ADVANCE_SPEED, adv);
		write_reg(REG_CORRECT_RATIO, ratio);
		write_reg(REG_LEVEL_BAND, band);
		write_reg(REG_SETTLE_TICKS, ticks);
		write_reg(REG_BRAKE_SPEED, brk);
		write_reg(REG_TILT_IND_LIMIT, lim);
		write_reg(REG_CORRECT_OFFSET, off);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed ticks at reset settings
		queue_tick(0, 0, 0, 0, 0, 0, 0, 0);
		queue_tick(9000, 32767, -32768, 32767, 0, 0, 0, 0);
		queue_tick(-9000, -32768, 32767, -32768, 0, 0, 0, 0);
		queue_tick(500, 1, -1, 0, 0, 0, 0, 0);
		queue_tick(-501, 0, 0, 0, 0, 0, 0, 0);
		queue_tick(16383, 0, 0, 0, 0, 0, 1, 0);
		queue_tick(-16384, 0, 0, 0, 0, 0, 0, 1);
		queue_tick(0, 0, 0, 0, 0, 0, 0, 1);
		queue_tick(0, 0, 0, 0, 0, 0, 0, 0);
		queue_tick(0, 0, 0, 0, 0, 0, 0, 1);
		// brake alone re-enters braking each tick
		queue_tick(100, 500, 7, 7, 0, 1, 0, 0);
		queue_tick(100, 0, 0, 0, 0, 1, 0, 0);
		queue_tick(0, 1000, 0, 0, 0, 0, 0, 0);
		// advance, peak, correct by division, settle, brake
		queue_tick(2000, 0, 11, 22, 1, 0, 0, 0);
		queue_tick(3000, 0, 0, 0, 1, 0, 0, 0);
		queue_tick(2500, 0, 0, 0, 1, 0, 0, 0);
		queue_tick(50, 4321, 0, 0, 1, 0, 0, 0);
		queue_tick(-50, 0, 0, 0, 1, 0, 0, 0);
		queue_tick(20, 0, 0, 0, 1, 0, 0, 0);
		queue_tick(0, 0, 0, 0, 1, 0, 0, 0);
		queue_tick(99, 0, 0, 0, 1, 0, 0, 0);
		queue_tick(99, 0, 0, 0, 1, 0, 1, 0);
		// negative direction entry
		queue_tick(0, -2000, 0, 0, 0, 0, 0, 0);
		queue_tick(-300, 0, 0, 0, 1, 0, 0, 0);
		// positive direction against the tilt: correcting with a zero peak
		queue_tick(0, 5000, 0, 0, 0, 0, 0, 0);
		queue_tick(-300, 0, 0, 0, 1, 0, 0, 0);
		queue_random_ticks(PHASE_TICKS);
		wait_idle();

		apply_settings(32767, 511, 16383, 255, 32767, 16383, 32767);
		queue_random_ticks(PHASE_TICKS);
		wait_idle();

		apply_settings(0, 0, 0, 0, 0, 0, 0);
		queue_random_ticks(PHASE_TICKS);
		wait_idle();

		apply_settings(16000, 256, 300, 1, 20000, 9000, 0);
		queue_random_ticks(PHASE_TICKS);
		wait_idle();

		repeat (2) begin
			apply_settings($urandom_range(0, 32767), $urandom_range(0, 300),
				$urandom_range(0, 1500), $urandom_range(0, 12), $urandom_range(0, 32767),
				$urandom_range(0, 9000), $urandom_range(0, 32767));
			queue_random_ticks(PHASE_TICKS);
			wait_idle();
		end

		repeat (30) @(posedge clk);
		$display("%0d ticks sent, %0d drive commands checked, %0d register writes",
			n_ticks_in, n_cmds_out, n_cfg_writes);
		$display("balance ticks: %0d advancing, %0d correcting, %0d braking",
			n_advancing, n_correcting, n_braking);
		if (n_errors == 0)
			$display("tilt_auto_balance_drive_top verification clean");
		else
			$display("tilt_auto_balance_drive_top verification failed");
		$finish;
	end

endmodule
